// File: src/tsb_pkg.sv
package tsb_pkg;

  localparam int TSB_MAX_WIDTH    = 2048;
  localparam int TSB_TANH_ENTRIES = 2048;

  localparam int ROW_W       = 12;
  localparam int CFG_ADDR_W  = 5;
  localparam int QUEUE_DEPTH = 2;

  // Mean of nine: (sum + 4) / 9 taken as a reciprocal product, exact for sums below 2300.
  localparam int MEAN_BIAS  = 4;
  localparam int MEAN_RECIP = 7282;
  localparam int MEAN_SHIFT = 16;

  localparam int Q15_ONE  = 32768;
  localparam int Q15_HALF = 16384;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    REG_BAND_HEIGHT  = 3'd0,
    REG_DECAY        = 3'd1,
    REG_POSITION     = 3'd2,
    REG_LINE_WIDTH   = 3'd3,
    REG_FRAME_HEIGHT = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [11:0] band_height;
    logic [6:0]  decay;
    logic [11:0] position;
    logic [11:0] line_width;
    logic [11:0] frame_height;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       slot_top;
    logic [1:0]       slot_mid;
    logic [1:0]       slot_bot;
    logic [ROW_W-1:0] row;
    logic             new_row;
    logic             fend;
  } job_ctl_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_WGT,
    B_RD,
    B_MEAN,
    B_BLEND,
    B_OUT
  } back_state_t;

  typedef enum logic [2:0] {
    W_IDLE,
    W_PREP,
    W_CHK,
    W_DIV,
    W_ROM,
    W_LUT,
    W_ACC
  } wgt_state_t;

endpackage

// File: src/tsb_ifs.sv
interface tsb_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] blue_in;
  logic [7:0] green_in;
  logic [7:0] red_in;

  modport source (output valid, op, blue_in, green_in, red_in, input ready);
  modport sink (input valid, op, blue_in, green_in, red_in, output ready);
endinterface

interface tsb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue_out;
  logic [7:0] green_out;
  logic [7:0] red_out;
  logic       frame_end;

  modport source (output valid, blue_out, green_out, red_out, frame_end, input ready);
  modport sink (input valid, blue_out, green_out, red_out, frame_end, output ready);
endinterface

// File: src/tsb_front.sv
module tsb_front #(
  parameter int MAX_WIDTH = tsb_pkg::TSB_MAX_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  tsb_in_if.sink                             in_ch,
  input  tsb_pkg::cfg_t                      cfg,
  input  logic                               back_busy,
  input  logic                               q_empty,
  output logic                               push,
  output tsb_pkg::job_ctl_t                  push_ctl,
  output logic [2:0][$clog2(MAX_WIDTH)-1:0]  push_cols,
  output logic                               wr_en,
  output logic [1:0]                         wr_slot,
  output logic [$clog2(MAX_WIDTH)-1:0]       wr_addr,
  output logic [23:0]                        wr_data
);
  import tsb_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int LW = (WW > ROW_W) ? WW : ROW_W;
  localparam int PW = $clog2(MAX_WIDTH + 3);

  logic [CW-1:0]    in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [ROW_W-1:0] in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic [1:0]       in_slot_r, in_slot_nxt, out_slot_r, out_slot_nxt;
  logic [PW-1:0]    pend_r, pend_nxt, pend_inc, pend_base;
  logic [LW-1:0]    lw_ext;
  logic [WW-1:0]    w_eff, in_col_inc, out_col_inc, c_ext;
  logic [ROW_W-1:0] h_eff;
  logic [ROW_W:0]   in_row_inc, out_row_inc;
  logic             accept, is_pix, emit;

  assign lw_ext = LW'(cfg.line_width);
  always_comb begin
    if (lw_ext < LW'(2)) begin
      w_eff = WW'(2);
    end else if (lw_ext > LW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(lw_ext);
    end
  end
  assign h_eff = (cfg.frame_height < 12'd2) ? 12'd2 : cfg.frame_height;

  // A new beat waits until the back end has read the line stores for the last job.
  assign in_ch.ready = q_empty && !back_busy;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_pix      = (in_ch.op == OP_PIXEL);

  assign pend_inc  = pend_r + PW'(1);
  assign emit      = is_pix ? (pend_inc > (PW'(w_eff) + PW'(1))) : (pend_r != '0);
  assign pend_base = is_pix ? pend_inc : pend_r;

  assign wr_en   = accept && is_pix;
  assign wr_slot = in_slot_r;
  assign wr_addr = in_col_r;
  assign wr_data = {in_ch.red_in, in_ch.green_in, in_ch.blue_in};

  assign in_col_inc  = WW'(in_col_r) + WW'(1);
  assign in_row_inc  = {1'b0, in_row_r} + 13'd1;
  assign out_col_inc = WW'(out_col_r) + WW'(1);
  assign out_row_inc = {1'b0, out_row_r} + 13'd1;
  assign c_ext       = WW'(out_col_r);

  always_comb begin
    in_col_nxt   = in_col_r;
    in_row_nxt   = in_row_r;
    in_slot_nxt  = in_slot_r;
    out_col_nxt  = out_col_r;
    out_row_nxt  = out_row_r;
    out_slot_nxt = out_slot_r;
    pend_nxt     = pend_r;
    push         = 1'b0;

    push_ctl.new_row  = (out_col_r == '0);
    push_ctl.row      = out_row_r;
    push_ctl.slot_mid = out_slot_r;
    push_ctl.slot_top = (out_row_r == '0) ? 2'(out_slot_r + 2'd1) : 2'(out_slot_r + 2'd3);
    push_ctl.slot_bot = (out_row_inc >= {1'b0, h_eff}) ? 2'(out_slot_r + 2'd3)
                                                       : 2'(out_slot_r + 2'd1);
    push_ctl.fend     = (out_col_inc >= w_eff) && (out_row_inc >= {1'b0, h_eff});

    push_cols[1] = out_col_r;
    push_cols[0] = (out_col_r != '0) ? CW'(c_ext - WW'(1)) : CW'(c_ext + WW'(1));
    push_cols[2] = (out_col_inc < w_eff) ? CW'(out_col_inc) : CW'(c_ext - WW'(1));

    if (accept) begin
      if (is_pix) begin
        if (in_col_inc >= w_eff) begin
          in_col_nxt  = '0;
          in_slot_nxt = 2'(in_slot_r + 2'd1);
          in_row_nxt  = (in_row_inc >= {1'b0, h_eff}) ? '0 : in_row_inc[ROW_W-1:0];
        end else begin
          in_col_nxt = CW'(in_col_inc);
        end
      end
      pend_nxt = emit ? (pend_base - PW'(1)) : pend_base;
      if (emit) begin
        push = 1'b1;
        if (out_col_inc >= w_eff) begin
          out_col_nxt  = '0;
          out_slot_nxt = 2'(out_slot_r + 2'd1);
          out_row_nxt  = (out_row_inc >= {1'b0, h_eff}) ? '0 : out_row_inc[ROW_W-1:0];
        end else begin
          out_col_nxt = CW'(out_col_inc);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r   <= '0;
      in_row_r   <= '0;
      in_slot_r  <= '0;
      out_col_r  <= '0;
      out_row_r  <= '0;
      out_slot_r <= '0;
      pend_r     <= '0;
    end else begin
      in_col_r   <= in_col_nxt;
      in_row_r   <= in_row_nxt;
      in_slot_r  <= in_slot_nxt;
      out_col_r  <= out_col_nxt;
      out_row_r  <= out_row_nxt;
      out_slot_r <= out_slot_nxt;
      pend_r     <= pend_nxt;
    end
  end

endmodule

// File: src/tsb_queue.sv
module tsb_queue #(
  parameter int MAX_WIDTH = tsb_pkg::TSB_MAX_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               push,
  input  tsb_pkg::job_ctl_t                  push_ctl,
  input  logic [2:0][$clog2(MAX_WIDTH)-1:0]  push_cols,
  input  logic                               pop,
  output logic                               empty,
  output tsb_pkg::job_ctl_t                  head_ctl,
  output logic [2:0][$clog2(MAX_WIDTH)-1:0]  head_cols
);
  import tsb_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  job_ctl_t             ctl_mem [QUEUE_DEPTH];
  logic [2:0][CW-1:0]   col_mem [QUEUE_DEPTH];
  logic [QPW-1:0]       wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0]       cnt_r;
  logic                 full, do_push, do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == QCW'(QUEUE_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  assign head_ctl  = ctl_mem[rd_ptr_r];
  assign head_cols = col_mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      ctl_mem[wr_ptr_r] <= push_ctl;
      col_mem[wr_ptr_r] <= push_cols;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPW'(QUEUE_DEPTH - 1)) ? '0 : QPW'(wr_ptr_r + QPW'(1));
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPW'(QUEUE_DEPTH - 1)) ? '0 : QPW'(rd_ptr_r + QPW'(1));
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + QCW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - QCW'(1);
      end
    end
  end

endmodule

// File: src/tsb_weight.sv
module tsb_weight #(
  parameter int TANH_ENTRIES = tsb_pkg::TSB_TANH_ENTRIES
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [tsb_pkg::ROW_W-1:0] row,
  input  tsb_pkg::cfg_t            cfg,
  output logic                     done,
  output logic [15:0]              weight
);
  import tsb_pkg::*;

  localparam int QB  = $clog2(TANH_ENTRIES);
  localparam int BW  = $clog2(QB);
  localparam int NW  = $clog2(TANH_ENTRIES + 1);
  localparam int DVW = 14 + NW;

  typedef logic [15:0] rom_t [TANH_ENTRIES];

  function automatic logic [63:0] div64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], a[i]};
      if (r >= b) begin
        r    = r - b;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // tanh(8k/N) in Q15, built from e^(-16k/N) stepped in Q32.
  function automatic rom_t build_rom();
    rom_t        rom;
    logic [63:0] term;
    logic [63:0] s;
    logic [63:0] e;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] q;
    term = 64'h1_0000_0000;
    s    = term;
    e    = term;
    for (int n = 1; n <= 16; n++) begin
      term = div64(term * 64'd16, 64'(TANH_ENTRIES) * 64'(n));
      if ((n % 2) == 1) begin
        s = s - term;
      end else begin
        s = s + term;
      end
    end
    for (int k = 0; k < TANH_ENTRIES; k++) begin
      num    = (64'h1_0000_0000 - e) * 64'd32768;
      den    = 64'h1_0000_0000 + e;
      q      = div64(num + (den >> 1), den);
      rom[k] = q[15:0];
      e      = (e * s + 64'h8000_0000) >> 32;
    end
    return rom;
  endfunction

  localparam rom_t TANH_ROM = build_rom();

  wgt_state_t          state_r, state_nxt;
  logic                sel_r, sel_nxt, neg_r, neg_nxt, done_r, done_nxt;
  logic signed [13:0]  num_r, num_nxt, n2_r, n2_nxt, n1_c, n2_c, mag_s;
  logic [DVW-1:0]      rem_r, rem_nxt, lim_r, lim_nxt, dv_r, dv_nxt, dv_sh;
  logic [QB-1:0]       q_r, q_nxt;
  logic [BW-1:0]       bit_r, bit_nxt;
  logic [15:0]         t_r, t_nxt, rom_q_r, weight_r, weight_nxt;
  logic signed [16:0]  t1_r, t1_nxt, ts;
  logic signed [17:0]  diff;
  logic [16:0]         diff_c;
  logic [7:0]          dcy1;

  assign done   = done_r;
  assign weight = weight_r;

  assign dcy1  = {1'b0, cfg.decay} + 8'd1;
  assign n1_c  = $signed({2'b00, row}) - $signed({2'b00, cfg.position});
  assign n2_c  = n1_c - $signed({2'b00, cfg.band_height});
  assign mag_s = num_r[13] ? -num_r : num_r;
  assign dv_sh = dv_r << bit_r;
  assign ts    = neg_r ? -$signed({1'b0, t_r}) : $signed({1'b0, t_r});
  assign diff  = 18'(t1_r) - 18'(ts);

  always_comb begin
    if (diff[17]) begin
      diff_c = '0;
    end else if (diff > 18'sd65536) begin
      diff_c = 17'd65536;
    end else begin
      diff_c = diff[16:0];
    end
  end

  always_ff @(posedge clk) begin
    rom_q_r <= TANH_ROM[q_r];
  end

  always_comb begin
    state_nxt  = state_r;
    sel_nxt    = sel_r;
    neg_nxt    = neg_r;
    num_nxt    = num_r;
    n2_nxt     = n2_r;
    rem_nxt    = rem_r;
    lim_nxt    = lim_r;
    dv_nxt     = dv_r;
    q_nxt      = q_r;
    bit_nxt    = bit_r;
    t_nxt      = t_r;
    t1_nxt     = t1_r;
    weight_nxt = weight_r;
    done_nxt   = 1'b0;
    case (state_r)
      W_IDLE: begin
        if (start) begin
          num_nxt   = n1_c;
          n2_nxt    = n2_c;
          sel_nxt   = 1'b0;
          state_nxt = W_PREP;
        end
      end
      W_PREP: begin
        neg_nxt   = num_r[13];
        rem_nxt   = DVW'(mag_s[12:0]) * DVW'(TANH_ENTRIES) + (DVW'(dcy1) << 2);
        dv_nxt    = DVW'(dcy1) << 3;
        lim_nxt   = DVW'(dcy1) * DVW'(8 * TANH_ENTRIES);
        q_nxt     = '0;
        state_nxt = W_CHK;
      end
      W_CHK: begin
        if (rem_r >= lim_r) begin
          t_nxt     = 16'(Q15_ONE);
          state_nxt = W_ACC;
        end else begin
          bit_nxt   = BW'(QB - 1);
          state_nxt = W_DIV;
        end
      end
      W_DIV: begin
        if (rem_r >= dv_sh) begin
          rem_nxt        = rem_r - dv_sh;
          q_nxt[bit_r]   = 1'b1;
        end
        if (bit_r == '0) begin
          state_nxt = W_ROM;
        end else begin
          bit_nxt = bit_r - BW'(1);
        end
      end
      W_ROM: begin
        state_nxt = W_LUT;
      end
      W_LUT: begin
        t_nxt     = rom_q_r;
        state_nxt = W_ACC;
      end
      W_ACC: begin
        if (!sel_r) begin
          t1_nxt    = ts;
          num_nxt   = n2_r;
          sel_nxt   = 1'b1;
          state_nxt = W_PREP;
        end else begin
          weight_nxt = 16'((diff_c + 17'd1) >> 1);
          done_nxt   = 1'b1;
          state_nxt  = W_IDLE;
        end
      end
      default: begin
        state_nxt = W_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= W_IDLE;
      done_r   <= 1'b0;
      weight_r <= '0;
    end else begin
      state_r  <= state_nxt;
      done_r   <= done_nxt;
      weight_r <= weight_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sel_r <= sel_nxt;
    neg_r <= neg_nxt;
    num_r <= num_nxt;
    n2_r  <= n2_nxt;
    rem_r <= rem_nxt;
    lim_r <= lim_nxt;
    dv_r  <= dv_nxt;
    q_r   <= q_nxt;
    bit_r <= bit_nxt;
    t_r   <= t_nxt;
    t1_r  <= t1_nxt;
  end

endmodule

// File: src/tsb_back.sv
module tsb_back #(
  parameter int MAX_WIDTH = tsb_pkg::TSB_MAX_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_empty,
  input  tsb_pkg::job_ctl_t                  q_ctl,
  input  logic [2:0][$clog2(MAX_WIDTH)-1:0]  q_cols,
  output logic                               pop,
  input  logic                               wr_en,
  input  logic [1:0]                         wr_slot,
  input  logic [$clog2(MAX_WIDTH)-1:0]       wr_addr,
  input  logic [23:0]                        wr_data,
  output logic                               busy,
  output logic                               wgt_start,
  output logic [tsb_pkg::ROW_W-1:0]          wgt_row,
  input  logic                               wgt_done,
  input  logic [15:0]                        wgt_weight,
  tsb_out_if.source                          out_ch
);
  import tsb_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  back_state_t          state_r, state_nxt;
  job_ctl_t             ctl_r, ctl_nxt;
  logic [2:0][CW-1:0]   cols_r, cols_nxt;
  logic [CW-1:0]        rd_addr;
  logic [1:0]           cnt_r, cnt_nxt;
  logic [2:0][11:0]     sum_r, sum_nxt;
  logic [2:0][7:0]      mean_r, mean_nxt, res_r, res_nxt;
  logic [23:0]          center_r, center_nxt, top_q, mid_q, bot_q;
  logic [15:0]          wt_r, wt_nxt, wt_inv;
  logic [23:0]          bank_q [4];
  logic                 out_valid_r, out_valid_nxt, out_fend_r, out_fend_nxt;
  logic [23:0]          out_pix_r, out_pix_nxt;
  logic [24:0]          mprod [3];
  logic [23:0]          blend [3];

  // Four line banks in a ring, each with one write and one registered read port.
  for (genvar g = 0; g < 4; g++) begin : g_bank
    logic [23:0] mem [MAX_WIDTH];
    logic [23:0] q_r;
    always_ff @(posedge clk) begin
      if (wr_en && (wr_slot == 2'(g))) begin
        mem[wr_addr] <= wr_data;
      end
      q_r <= mem[rd_addr];
    end
    assign bank_q[g] = q_r;
  end

  assign top_q  = bank_q[ctl_r.slot_top];
  assign mid_q  = bank_q[ctl_r.slot_mid];
  assign bot_q  = bank_q[ctl_r.slot_bot];
  assign wt_inv = 16'(Q15_ONE) - wt_r;

  always_comb begin
    case (cnt_r)
      2'd0:    rd_addr = cols_r[0];
      2'd1:    rd_addr = cols_r[1];
      default: rd_addr = cols_r[2];
    endcase
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      mprod[ch] = 25'(sum_r[ch] + 12'(MEAN_BIAS)) * 25'(MEAN_RECIP);
      blend[ch] = 24'(center_r[ch*8 +: 8]) * 24'(wt_r) + 24'(mean_r[ch]) * 24'(wt_inv)
                  + 24'(Q15_HALF);
    end
  end

  assign busy      = (state_r == B_WGT) || (state_r == B_RD);
  // The weight unit latches the row in the cycle the job leaves the queue.
  assign wgt_row   = q_ctl.row;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.blue_out  = out_pix_r[7:0];
  assign out_ch.green_out = out_pix_r[15:8];
  assign out_ch.red_out   = out_pix_r[23:16];
  assign out_ch.frame_end = out_fend_r;

  always_comb begin
    state_nxt     = state_r;
    ctl_nxt       = ctl_r;
    cols_nxt      = cols_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    mean_nxt      = mean_r;
    res_nxt       = res_r;
    center_nxt    = center_r;
    wt_nxt        = wt_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_pix_nxt   = out_pix_r;
    out_fend_nxt  = out_fend_r;
    pop           = 1'b0;
    wgt_start     = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          pop      = 1'b1;
          ctl_nxt  = q_ctl;
          cols_nxt = q_cols;
          cnt_nxt  = '0;
          sum_nxt  = '0;
          if (q_ctl.new_row) begin
            state_nxt = B_WGT;
          end else begin
            state_nxt = B_RD;
          end
        end
      end
      B_WGT: begin
        wgt_start = 1'b0;
        if (wgt_done) begin
          wt_nxt    = wgt_weight;
          state_nxt = B_RD;
        end
      end
      B_RD: begin
        // Reads go out one column per cycle; data of the previous column lands now.
        if (cnt_r != 2'd0) begin
          for (int ch = 0; ch < 3; ch++) begin
            sum_nxt[ch] = sum_r[ch] + 12'(top_q[ch*8 +: 8]) + 12'(mid_q[ch*8 +: 8])
                          + 12'(bot_q[ch*8 +: 8]);
          end
        end
        if (cnt_r == 2'd2) begin
          center_nxt = mid_q;
        end
        if (cnt_r == 2'd3) begin
          state_nxt = B_MEAN;
        end else begin
          cnt_nxt = cnt_r + 2'd1;
        end
      end
      B_MEAN: begin
        for (int ch = 0; ch < 3; ch++) begin
          mean_nxt[ch] = mprod[ch][MEAN_SHIFT +: 8];
        end
        state_nxt = B_BLEND;
      end
      B_BLEND: begin
        for (int ch = 0; ch < 3; ch++) begin
          res_nxt[ch] = blend[ch][22:15];
        end
        state_nxt = B_OUT;
      end
      B_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_pix_nxt   = {res_r[2], res_r[1], res_r[0]};
          out_fend_nxt  = ctl_r.fend;
          state_nxt     = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
    if ((state_r == B_IDLE) && !q_empty && q_ctl.new_row) begin
      wgt_start = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      wt_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      wt_r        <= wt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ctl_r      <= ctl_nxt;
    cols_r     <= cols_nxt;
    cnt_r      <= cnt_nxt;
    sum_r      <= sum_nxt;
    mean_r     <= mean_nxt;
    res_r      <= res_nxt;
    center_r   <= center_nxt;
    out_pix_r  <= out_pix_nxt;
    out_fend_r <= out_fend_nxt;
  end

endmodule

// File: src/tilt_shift_blend.sv
// Channel   Direction  Handshake          Beat contents
// in_ch     sink       valid/ready        op, blue_in, green_in, red_in
// out_ch    source     valid/ready        blue_out, green_out, red_out, frame_end
// cfg_*     slave      APB, pready high   five registers at byte address 4*index
//
// A pixel beat that causes no result does not hold the input. A beat that releases a result
// holds the input until the back end has taken the job from the queue and has read three
// columns from the line banks, each of which has a single read port.
// The first result of each row adds two tanh lookups through the serial divider, which
// uses QB = clog2(TANH_ENTRIES) quotient bits. Reset is synchronous and active low;
// the line banks hold no reset. The output register takes a stall on its own.
module tilt_shift_blend #(
  parameter int MAX_WIDTH    = tsb_pkg::TSB_MAX_WIDTH,
  parameter int TANH_ENTRIES = tsb_pkg::TSB_TANH_ENTRIES
) (
  input  logic                            clk,
  input  logic                            rst_n,
  tsb_in_if.sink                          in_ch,
  tsb_out_if.source                       out_ch,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [tsb_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]                     cfg_pwdata,
  output logic [31:0]                     cfg_prdata,
  output logic                            cfg_pready
);
  import tsb_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  cfg_t               cfg_r;
  reg_idx_t           reg_idx;
  logic               cfg_wr;
  logic               push, pop, q_empty, back_busy;
  job_ctl_t           push_ctl, head_ctl;
  logic [2:0][CW-1:0] push_cols, head_cols;
  logic               wr_en;
  logic [1:0]         wr_slot;
  logic [CW-1:0]      wr_addr;
  logic [23:0]        wr_data;
  logic               wgt_start, wgt_done;
  logic [ROW_W-1:0]   wgt_row;
  logic [15:0]        wgt_weight;

  // Register file. The word index is the byte address over four; writes to the unused
  // indexes fall through to nothing.
  assign cfg_pready = 1'b1;
  assign reg_idx    = reg_idx_t'(cfg_paddr[CFG_ADDR_W-1:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.band_height  <= 12'd0;
      cfg_r.decay        <= 7'd0;
      cfg_r.position     <= 12'd0;
      cfg_r.line_width   <= 12'd640;
      cfg_r.frame_height <= 12'd480;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_BAND_HEIGHT:  cfg_r.band_height  <= cfg_pwdata[11:0];
        REG_DECAY:        cfg_r.decay        <= cfg_pwdata[6:0];
        REG_POSITION:     cfg_r.position     <= cfg_pwdata[11:0];
        REG_LINE_WIDTH:   cfg_r.line_width   <= cfg_pwdata[11:0];
        REG_FRAME_HEIGHT: cfg_r.frame_height <= cfg_pwdata[11:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BAND_HEIGHT:  cfg_prdata = 32'(cfg_r.band_height);
      REG_DECAY:        cfg_prdata = 32'(cfg_r.decay);
      REG_POSITION:     cfg_prdata = 32'(cfg_r.position);
      REG_LINE_WIDTH:   cfg_prdata = 32'(cfg_r.line_width);
      REG_FRAME_HEIGHT: cfg_prdata = 32'(cfg_r.frame_height);
      default:          cfg_prdata = 32'd0;
    endcase
  end

  // The front end owns the stream counters and writes each pixel into its ring slot.
  // It decides whether a beat releases a result and queues a job with the window
  // addresses worked out already.
  tsb_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg       (cfg_r),
    .back_busy (back_busy),
    .q_empty   (q_empty),
    .push      (push),
    .push_ctl  (push_ctl),
    .push_cols (push_cols),
    .wr_en     (wr_en),
    .wr_slot   (wr_slot),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  tsb_queue #(.MAX_WIDTH(MAX_WIDTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_ctl  (push_ctl),
    .push_cols (push_cols),
    .pop       (pop),
    .empty     (q_empty),
    .head_ctl  (head_ctl),
    .head_cols (head_cols)
  );

  // The row weight is refreshed at the first result of each row, from the registers
  // as they stand then.
  tsb_weight #(.TANH_ENTRIES(TANH_ENTRIES)) u_weight (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (wgt_start),
    .row    (wgt_row),
    .cfg    (cfg_r),
    .done   (wgt_done),
    .weight (wgt_weight)
  );

  // The back end reads the 3x3 window, forms the rounded mean and blends it with the
  // center pixel into the output register.
  tsb_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_ctl      (head_ctl),
    .q_cols     (head_cols),
    .pop        (pop),
    .wr_en      (wr_en),
    .wr_slot    (wr_slot),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .busy       (back_busy),
    .wgt_start  (wgt_start),
    .wgt_row    (wgt_row),
    .wgt_done   (wgt_done),
    .wgt_weight (wgt_weight),
    .out_ch     (out_ch)
  );

endmodule
